/* sv/htp_pkg.sv */
package htp_pkg;

    localparam int POS_W      = 24;
    localparam int PRED_W     = 32;
    localparam int TS_W       = 32;
    localparam int LVL_W      = 32;
    localparam int VEL_W      = 40;
    localparam int GAIN_W     = 17;
    localparam int LEAD_W     = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LEAD = 2'd1;

    localparam logic [GAIN_W-1:0] GAIN_ONE   = 17'd65536;
    localparam logic [GAIN_W-1:0] GAIN_MIN   = 17'd655;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd32768;
    localparam logic [LEAD_W-1:0] LEAD_MAX   = 20'd1000000;
    localparam logic [LEAD_W-1:0] LEAD_RESET = 20'd16000;

    localparam int MUL_A_W = 41;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int DIV_N_W   = 50;
    localparam int DIV_D_W   = 31;
    localparam int DIV_R_W   = DIV_D_W + 1;
    localparam int DIV_STEPS = DIV_N_W / 2;
    localparam int DIV_CNT_W = 5;

    typedef struct packed {
        logic                     clear;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic [TS_W-1:0]          timestamp_us;
    } htp_in_t;

    typedef struct packed {
        logic signed [PRED_W-1:0] pred_x;
        logic signed [PRED_W-1:0] pred_y;
        logic                     primed;
        logic                     skipped;
    } htp_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } htp_div_stat_t;

endpackage

/* sv/holt_trend_position_predictor_unit.sv */
// Transactions are handled one at a time: s_ready is high only in the idle state, which is
// reentered once the result has moved to the output register. The time for a filter update
// is set by the shared 2-bit-per-cycle divider and the shared multiplier.
// Reset (aresetn low, synchronous) clears the filter state and loads the register
// defaults: gain 32768, lead time 16000 us.
module holt_trend_position_predictor_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  htp_pkg::htp_in_t                   s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output htp_pkg::htp_out_t                  m_data,
    input  logic                               cfg_wr_en,
    input  logic [htp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [htp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_U0    = 4'd1;
    localparam logic [3:0] ST_U1    = 4'd2;
    localparam logic [3:0] ST_U2    = 4'd3;
    localparam logic [3:0] ST_U3    = 4'd4;
    localparam logic [3:0] ST_U4    = 4'd5;
    localparam logic [3:0] ST_U5    = 4'd6;
    localparam logic [3:0] ST_U6    = 4'd7;
    localparam logic [3:0] ST_U7    = 4'd8;
    localparam logic [3:0] ST_UWAIT = 4'd9;
    localparam logic [3:0] ST_P0    = 4'd10;
    localparam logic [3:0] ST_P1    = 4'd11;
    localparam logic [3:0] ST_FIN   = 4'd12;

    localparam int W  = htp_pkg::MUL_P_W;
    localparam int VW = htp_pkg::VEL_W;
    localparam int LW = htp_pkg::LVL_W;
    localparam int SW = VW + 12;

    localparam logic signed [W-1:0] RND_HALF = W'(32768);

    function automatic logic signed [LW-1:0] sat32(input logic signed [W-1:0] v);
        logic hi_same;
        hi_same = (&v[W-1:LW-1]) || !(|v[W-1:LW-1]);
        if (hi_same) begin
            sat32 = v[LW-1:0];
        end else begin
            sat32 = v[W-1] ? {1'b1, {(LW-1){1'b0}}} : {1'b0, {(LW-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [VW-1:0] sat40(input logic signed [SW-1:0] v);
        logic hi_same;
        hi_same = (&v[SW-1:VW-1]) || !(|v[SW-1:VW-1]);
        if (hi_same) begin
            sat40 = v[VW-1:0];
        end else begin
            sat40 = v[SW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        end
    endfunction

    logic [3:0]                          state_reg, state_next;
    logic [htp_pkg::GAIN_W-1:0]          gain_reg, gain_next;
    logic [htp_pkg::LEAD_W-1:0]          lead_reg, lead_next;
    logic                                primed_reg, primed_next;
    logic signed [LW-1:0]                lvl_reg [0:1];
    logic signed [LW-1:0]                lvl_next [0:1];
    logic signed [VW-1:0]                vel_reg [0:1];
    logic signed [VW-1:0]                vel_next [0:1];
    logic [htp_pkg::TS_W-1:0]            last_reg, last_next;
    htp_pkg::htp_in_t                    in_reg, in_next;
    logic [htp_pkg::DIV_D_W-1:0]         dt_reg, dt_next;
    logic                                axis_reg, axis_next;
    logic signed [W-1:0]                 acc_reg, acc_next;
    logic signed [LW-1:0]                p_reg, p_next;
    logic signed [LW-1:0]                nl_reg, nl_next;
    logic signed [VW:0]                  rv_reg, rv_next;
    logic                                neg_reg, neg_next;
    htp_pkg::htp_out_t                   res_reg, res_next;
    htp_pkg::htp_out_t                   m_data_reg, m_data_next;
    logic                                m_valid_reg, m_valid_next;

    logic signed [htp_pkg::MUL_A_W-1:0]  mul_a;
    logic signed [htp_pkg::MUL_B_W-1:0]  mul_b;
    logic signed [W-1:0]                 mul_p;
    logic                                div_start;
    logic [htp_pkg::DIV_N_W-1:0]         div_dividend;
    htp_pkg::htp_div_stat_t              div_stat;
    logic [htp_pkg::DIV_N_W-1:0]         div_quo;

    logic signed [LW-1:0]                cur_lvl;
    logic signed [VW-1:0]                cur_vel;
    logic signed [htp_pkg::POS_W-1:0]    cur_pos;
    logic [VW-1:0]                       vel_mag;
    logic [htp_pkg::GAIN_W-1:0]          gain_inv;
    logic [htp_pkg::TS_W-1:0]            dt_raw;
    logic signed [W-1:0]                 lvl_ext;
    logic signed [W-1:0]                 r_sum, r_sig, t_sum, num_mag;
    logic signed [LW:0]                  lvl_diff;
    logic signed [SW-1:0]                term, vel_sum;
    logic [htp_pkg::GAIN_W-1:0]          cfg_gain;
    logic [htp_pkg::LEAD_W-1:0]          cfg_lead;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    htp_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_p (mul_p)
    );

    htp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (dt_reg),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    // clamp register writes
    always_comb begin
        cfg_gain = cfg_wdata[htp_pkg::GAIN_W-1:0];
        if (cfg_gain < htp_pkg::GAIN_MIN) begin
            cfg_gain = htp_pkg::GAIN_MIN;
        end else if (cfg_gain > htp_pkg::GAIN_ONE) begin
            cfg_gain = htp_pkg::GAIN_ONE;
        end
        cfg_lead = cfg_wdata[htp_pkg::LEAD_W-1:0];
        if (cfg_lead > htp_pkg::LEAD_MAX) begin
            cfg_lead = htp_pkg::LEAD_MAX;
        end
        gain_next = gain_reg;
        lead_next = lead_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                htp_pkg::CFG_IDX_GAIN: gain_next = cfg_gain;
                htp_pkg::CFG_IDX_LEAD: lead_next = cfg_lead;
                default: ;
            endcase
        end
    end

    always_comb begin
        cur_lvl  = lvl_reg[axis_reg];
        cur_vel  = vel_reg[axis_reg];
        cur_pos  = axis_reg ? in_reg.pos_y : in_reg.pos_x;
        vel_mag  = cur_vel[VW-1] ? (VW'(0) - cur_vel) : cur_vel;
        gain_inv = htp_pkg::GAIN_ONE - gain_reg;
        dt_raw   = s_data.timestamp_us - last_reg;
        lvl_ext  = W'(cur_lvl);
        r_sum    = acc_reg + (mul_p >>> 16);
        r_sig    = neg_reg ? (W'(0) - r_sum) : r_sum;
        num_mag  = mul_p[W-1] ? (W'(0) - mul_p) : mul_p;
        lvl_diff = (LW+1)'(nl_reg) - (LW+1)'(cur_lvl);
        term     = neg_reg ? (SW'(0) - SW'({1'b0, div_quo})) : SW'({1'b0, div_quo});
        vel_sum  = term + SW'(rv_reg);
        t_sum    = '0;

        state_next   = state_reg;
        primed_next  = primed_reg;
        lvl_next     = lvl_reg;
        vel_next     = vel_reg;
        last_next    = last_reg;
        in_next      = in_reg;
        dt_next      = dt_reg;
        axis_next    = axis_reg;
        acc_next     = acc_reg;
        p_next       = p_reg;
        nl_next      = nl_reg;
        rv_next      = rv_reg;
        neg_next     = neg_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;

        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = num_mag[htp_pkg::DIV_N_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_next          = s_data;
                    axis_next        = 1'b0;
                    res_next         = '0;
                    if (s_data.clear) begin
                        primed_next = 1'b0;
                        lvl_next[0] = '0;
                        lvl_next[1] = '0;
                        vel_next[0] = '0;
                        vel_next[1] = '0;
                        last_next   = '0;
                        state_next  = ST_FIN;
                    end else if (!primed_reg) begin
                        primed_next     = 1'b1;
                        lvl_next[0]     = LW'(s_data.pos_x);
                        lvl_next[1]     = LW'(s_data.pos_y);
                        vel_next[0]     = '0;
                        vel_next[1]     = '0;
                        last_next       = s_data.timestamp_us;
                        res_next.primed = 1'b1;
                        state_next      = ST_P0;
                    end else if (dt_raw == '0 || dt_raw[htp_pkg::TS_W-1]) begin
                        res_next.primed  = 1'b1;
                        res_next.skipped = 1'b1;
                        state_next       = ST_P0;
                    end else begin
                        res_next.primed = 1'b1;
                        dt_next         = dt_raw[htp_pkg::DIV_D_W-1:0];
                        state_next      = ST_U0;
                    end
                end
            end
            ST_U0: begin
                mul_a      = htp_pkg::MUL_A_W'(dt_reg);
                mul_b      = htp_pkg::MUL_B_W'(vel_mag[VW-1:16]);
                neg_next   = cur_vel[VW-1];
                state_next = ST_U1;
            end
            ST_U1: begin
                acc_next   = mul_p;
                mul_a      = htp_pkg::MUL_A_W'(dt_reg);
                mul_b      = htp_pkg::MUL_B_W'(vel_mag[15:0]);
                state_next = ST_U2;
            end
            ST_U2: begin
                p_next     = sat32(lvl_ext + r_sig);
                mul_a      = htp_pkg::MUL_A_W'(cur_pos);
                mul_b      = htp_pkg::MUL_B_W'(gain_reg);
                state_next = ST_U3;
            end
            ST_U3: begin
                acc_next   = mul_p;
                mul_a      = htp_pkg::MUL_A_W'(p_reg);
                mul_b      = htp_pkg::MUL_B_W'(gain_inv);
                state_next = ST_U4;
            end
            ST_U4: begin
                t_sum      = acc_reg + mul_p + RND_HALF;
                nl_next    = t_sum[LW+15:16];
                state_next = ST_U5;
            end
            ST_U5: begin
                mul_a      = htp_pkg::MUL_A_W'(lvl_diff);
                mul_b      = htp_pkg::MUL_B_W'(gain_reg);
                state_next = ST_U6;
            end
            ST_U6: begin
                div_start  = 1'b1;
                neg_next   = mul_p[W-1];
                mul_a      = htp_pkg::MUL_A_W'(cur_vel);
                mul_b      = htp_pkg::MUL_B_W'(gain_inv);
                state_next = ST_U7;
            end
            ST_U7: begin
                t_sum      = mul_p + RND_HALF;
                rv_next    = t_sum[VW+16:16];
                state_next = ST_UWAIT;
            end
            ST_UWAIT: begin
                if (div_stat.done) begin
                    lvl_next[axis_reg] = nl_reg;
                    vel_next[axis_reg] = sat40(vel_sum);
                    if (!axis_reg) begin
                        axis_next  = 1'b1;
                        state_next = ST_U0;
                    end else begin
                        axis_next  = 1'b0;
                        last_next  = in_reg.timestamp_us;
                        state_next = ST_P0;
                    end
                end
            end
            ST_P0: begin
                mul_a      = htp_pkg::MUL_A_W'(cur_vel);
                mul_b      = htp_pkg::MUL_B_W'(lead_reg);
                state_next = ST_P1;
            end
            ST_P1: begin
                t_sum = mul_p + RND_HALF;
                if (axis_reg) begin
                    res_next.pred_y = sat32(lvl_ext + (t_sum >>> 16));
                    axis_next       = 1'b0;
                    state_next      = ST_FIN;
                end else begin
                    res_next.pred_x = sat32(lvl_ext + (t_sum >>> 16));
                    axis_next       = 1'b1;
                    state_next      = ST_P0;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            gain_reg    <= htp_pkg::GAIN_RESET;
            lead_reg    <= htp_pkg::LEAD_RESET;
            primed_reg  <= 1'b0;
            lvl_reg[0]  <= '0;
            lvl_reg[1]  <= '0;
            vel_reg[0]  <= '0;
            vel_reg[1]  <= '0;
            last_reg    <= '0;
            axis_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            gain_reg    <= gain_next;
            lead_reg    <= lead_next;
            primed_reg  <= primed_next;
            lvl_reg     <= lvl_next;
            vel_reg     <= vel_next;
            last_reg    <= last_next;
            axis_reg    <= axis_next;
            m_valid_reg <= m_valid_next;
        end
        in_reg     <= in_next;
        dt_reg     <= dt_next;
        acc_reg    <= acc_next;
        p_reg      <= p_next;
        nl_reg     <= nl_next;
        rv_reg     <= rv_next;
        neg_reg    <= neg_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_UWAIT))
        else $error("divider finished outside the wait state");

    a_idle_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !div_stat.busy)
        else $error("divider busy while ready for a transaction");

    a_unprime_by_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        ($fell(primed_reg) && $past(aresetn)) |-> $past(s_valid && s_ready && s_data.clear))
        else $error("filter lost its history without a clear");

    a_unprimed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && !res_reg.primed) |->
            (res_reg.pred_x == '0 && res_reg.pred_y == '0))
        else $error("nonzero prediction from an unprimed filter");

endmodule

/* sv/htp_mul.sv */
module htp_mul (
    input  logic                                 aclk,
    input  logic signed [htp_pkg::MUL_A_W-1:0]   mul_a,
    input  logic signed [htp_pkg::MUL_B_W-1:0]   mul_b,
    output logic signed [htp_pkg::MUL_P_W-1:0]   mul_p
);

    logic signed [htp_pkg::MUL_P_W-1:0] prod_reg;
    logic signed [htp_pkg::MUL_P_W-1:0] prod_next;

    assign prod_next = htp_pkg::MUL_P_W'(mul_a) * htp_pkg::MUL_P_W'(mul_b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign mul_p = prod_reg;

endmodule

/* sv/htp_div.sv */
module htp_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [htp_pkg::DIV_N_W-1:0]   dividend,
    input  logic [htp_pkg::DIV_D_W-1:0]   divisor,
    output htp_pkg::htp_div_stat_t        stat,
    output logic [htp_pkg::DIV_N_W-1:0]   quotient
);

    logic [htp_pkg::DIV_R_W-1:0]   rem_reg, rem_next;
    logic [htp_pkg::DIV_N_W-1:0]   quo_reg, quo_next;
    logic [htp_pkg::DIV_D_W-1:0]   dvs_reg, dvs_next;
    logic [htp_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;

    logic [htp_pkg::DIV_R_W-1:0]   dvs_ext;
    logic [htp_pkg::DIV_R_W-1:0]   r1, r1s, r2, r2s;
    logic                          ge1, ge2;

    // two restoring steps per cycle
    always_comb begin
        dvs_ext = {1'b0, dvs_reg};
        r1  = {rem_reg[htp_pkg::DIV_R_W-2:0], quo_reg[htp_pkg::DIV_N_W-1]};
        ge1 = (r1 >= dvs_ext);
        r1s = ge1 ? (r1 - dvs_ext) : r1;
        r2  = {r1s[htp_pkg::DIV_R_W-2:0], quo_reg[htp_pkg::DIV_N_W-2]};
        ge2 = (r2 >= dvs_ext);
        r2s = ge2 ? (r2 - dvs_ext) : r2;
    end

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = htp_pkg::DIV_CNT_W'(htp_pkg::DIV_STEPS - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = r2s;
            quo_next = {quo_reg[htp_pkg::DIV_N_W-3:0], ge1, ge2};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

/* test/holt_trend_position_predictor_unit_test.sv */
`timescale 1ns / 100ps

module holt_trend_position_predictor_unit_test;

    localparam longint signed PRED_HI = 64'sd2147483647;
    localparam longint signed PRED_LO = -64'sd2147483648;
    localparam longint signed VEL_HI = (64'sd1 <<< 39) - 64'sd1;
    localparam longint signed VEL_LO = -(64'sd1 <<< 39);
    localparam int POS_MAX = 8388607;
    localparam int POS_MIN = -8388608;
    localparam logic [htp_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE2 = 2'd2;
    localparam logic [htp_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE3 = 2'd3;
    localparam int QUIET_LIMIT = 4000;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int NUM_PHASES = 8;

    class holt_mirror;
        longint signed lvl_x, lvl_y, vel_x, vel_y;
        longint signed gain, lead;
        logic [htp_pkg::TS_W-1:0] stamp;
        bit primed;
        htp_pkg::htp_out_t pending_preds[$];
        int fails, n_samples, n_updates, n_skips, n_clears, n_results;

        function new();
            gain = longint'(htp_pkg::GAIN_RESET);
            lead = longint'(htp_pkg::LEAD_RESET);
            wipe();
        endfunction

        function void wipe();
            primed = 1'b0;
            lvl_x = 0;
            lvl_y = 0;
            vel_x = 0;
            vel_y = 0;
            stamp = '0;
        endfunction

        function void set_reg(logic [htp_pkg::CFG_IDX_W-1:0] idx,
                              logic [htp_pkg::CFG_DATA_W-1:0] data);
            longint signed v;
            case (idx)
                htp_pkg::CFG_IDX_GAIN: begin
                    v = longint'(data[htp_pkg::GAIN_W-1:0]);
                    if (v < longint'(htp_pkg::GAIN_MIN)) v = longint'(htp_pkg::GAIN_MIN);
                    if (v > longint'(htp_pkg::GAIN_ONE)) v = longint'(htp_pkg::GAIN_ONE);
                    gain = v;
                end
                htp_pkg::CFG_IDX_LEAD: begin
                    v = longint'(data[htp_pkg::LEAD_W-1:0]);
                    if (v > longint'(htp_pkg::LEAD_MAX)) v = longint'(htp_pkg::LEAD_MAX);
                    lead = v;
                end
                default: ;
            endcase
        endfunction

        function longint signed round16(longint signed v);
            return (v + 64'sd32768) >>> 16;
        endfunction

        function longint signed clamp(longint signed v, longint signed lo, longint signed hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function longint signed drift(longint signed vel, longint unsigned dt);
            longint unsigned mag, r;
            longint signed res;
            mag = vel < 0 ? -vel : vel;
            r = (mag >> 16) * dt + (((mag & 64'hFFFF) * dt) >> 16);
            res = r;
            if (vel < 0) res = -res;
            return res;
        endfunction

        function longint signed forecast(longint signed lvl, longint signed vel);
            return clamp(lvl + round16(vel * lead), PRED_LO, PRED_HI);
        endfunction

        function void update_axis(inout longint signed lvl, inout longint signed vel,
                                  input longint signed pos, input longint unsigned dt);
            longint signed p, nl, num, term, rest;
            longint unsigned mag, q;
            rest = longint'(htp_pkg::GAIN_ONE) - gain;
            p = clamp(lvl + drift(vel, dt), PRED_LO, PRED_HI);
            nl = round16(gain * pos + rest * p);
            num = gain * (nl - lvl);
            mag = num < 0 ? -num : num;
            q = mag / dt;
            term = q;
            if (num < 0) term = -term;
            vel = clamp(term + round16(rest * vel), VEL_LO, VEL_HI);
            lvl = nl;
        endfunction

        function void note_sample(htp_pkg::htp_in_t it);
            htp_pkg::htp_out_t want;
            logic [htp_pkg::TS_W-1:0] dt;
            longint signed fx, fy;
            bit skip;
            skip = 1'b0;
            n_samples++;
            if (it.clear) begin
                wipe();
                n_clears++;
            end else if (!primed) begin
                lvl_x = longint'($signed(it.pos_x));
                lvl_y = longint'($signed(it.pos_y));
                vel_x = 0;
                vel_y = 0;
                stamp = it.timestamp_us;
                primed = 1'b1;
            end else begin
                dt = it.timestamp_us - stamp;
                if (dt == '0 || dt[htp_pkg::TS_W-1]) begin
                    skip = 1'b1;
                    n_skips++;
                end else begin
                    update_axis(lvl_x, vel_x, longint'($signed(it.pos_x)), longint'(dt));
                    update_axis(lvl_y, vel_y, longint'($signed(it.pos_y)), longint'(dt));
                    stamp = it.timestamp_us;
                    n_updates++;
                end
            end
            fx = primed ? forecast(lvl_x, vel_x) : 0;
            fy = primed ? forecast(lvl_y, vel_y) : 0;
            want.pred_x = fx[htp_pkg::PRED_W-1:0];
            want.pred_y = fy[htp_pkg::PRED_W-1:0];
            want.primed = primed;
            want.skipped = skip;
            pending_preds.push_back(want);
        endfunction

        function void flag(string field, longint signed want, longint signed got);
            fails++;
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
        endfunction

        function void check_result(htp_pkg::htp_out_t got);
            htp_pkg::htp_out_t want;
            n_results++;
            if (pending_preds.size() == 0) begin
                fails++;
                $error("result with no sample pending: pred_x %0d, pred_y %0d",
                       $signed(got.pred_x), $signed(got.pred_y));
                return;
            end
            want = pending_preds.pop_front();
            if (got.pred_x !== want.pred_x)
                flag("pred_x", longint'($signed(want.pred_x)), longint'($signed(got.pred_x)));
            if (got.pred_y !== want.pred_y)
                flag("pred_y", longint'($signed(want.pred_y)), longint'($signed(got.pred_y)));
            if (got.primed !== want.primed)
                flag("primed", longint'(want.primed), longint'(got.primed));
            if (got.skipped !== want.skipped)
                flag("skipped", longint'(want.skipped), longint'(got.skipped));
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    htp_pkg::htp_in_t s_data;
    logic m_valid;
    logic m_ready = 1'b0;
    htp_pkg::htp_out_t m_data;
    logic cfg_wr_en;
    logic [htp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [htp_pkg::CFG_DATA_W-1:0] cfg_wdata;

    holt_mirror sb;
    int gap_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    int trk_x = 0;
    int trk_y = 0;
    int step_x = 300;
    int step_y = -200;

    holt_trend_position_predictor_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                sb.check_result(m_data);
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int clamp24(int v);
        return v < POS_MIN ? POS_MIN : (v > POS_MAX ? POS_MAX : v);
    endfunction

    function automatic logic [htp_pkg::CFG_DATA_W-1:0] cfg_val(int unsigned v);
        return htp_pkg::CFG_DATA_W'(v);
    endfunction

    function automatic htp_pkg::htp_in_t mk(bit clr, int x, int y,
                                            logic [htp_pkg::TS_W-1:0] ts);
        htp_pkg::htp_in_t it;
        it.clear = clr;
        it.pos_x = htp_pkg::POS_W'(x);
        it.pos_y = htp_pkg::POS_W'(y);
        it.timestamp_us = ts;
        return it;
    endfunction

    function automatic htp_pkg::htp_in_t next_sample();
        htp_pkg::htp_in_t it;
        int r;
        logic [htp_pkg::TS_W-1:0] dt;
        r = $urandom_range(99);
        it = mk(1'b0, $urandom, $urandom, $urandom);
        if (r < 2) begin
            it.clear = 1'b1;
        end else if (r >= 7) begin
            if ($urandom_range(15) == 0) step_x = int'($urandom_range(0, 40000)) - 20000;
            if ($urandom_range(15) == 0) step_y = int'($urandom_range(0, 40000)) - 20000;
            trk_x = clamp24(trk_x + step_x);
            trk_y = clamp24(trk_y + step_y);
            it.pos_x = htp_pkg::POS_W'(clamp24(trk_x + int'($urandom_range(0, 512)) - 256));
            it.pos_y = htp_pkg::POS_W'(clamp24(trk_y + int'($urandom_range(0, 512)) - 256));
            if (r < 13) begin
                it.timestamp_us = sb.stamp - $urandom_range(0, 3);
            end else begin
                case ($urandom_range(9))
                    0: dt = 1;
                    1: dt = $urandom_range(2, 100);
                    9: dt = $urandom_range(100000, 32'h7FFF_FFFF);
                    default: dt = $urandom_range(500, 40000);
                endcase
                it.timestamp_us = sb.stamp + dt;
            end
        end
        return it;
    endfunction

    task automatic send_item(input htp_pkg::htp_in_t it);
        int gap;
        s_data <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_sample(it);
        gap = 0;
        while ($urandom_range(99) < gap_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_preds.size() != 0) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [htp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [htp_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.set_reg(idx, data);
    endtask

    task automatic apply_regs(input logic [htp_pkg::CFG_DATA_W-1:0] gain_data,
                              input logic [htp_pkg::CFG_DATA_W-1:0] lead_data, input bit spare);
        drain_results();
        repeat (8) @(posedge aclk);
        if (spare) begin
            cfg_write(CFG_IDX_SPARE2, cfg_val($urandom));
            cfg_write(CFG_IDX_SPARE3, cfg_val($urandom));
        end
        cfg_write(htp_pkg::CFG_IDX_GAIN, gain_data);
        cfg_write(htp_pkg::CFG_IDX_LEAD, lead_data);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int phase;
        sb = new();
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= htp_pkg::CFG_IDX_GAIN;
        cfg_wdata <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(mk(1'b1, $urandom, $urandom, $urandom));
        send_item(mk(1'b0, POS_MAX, POS_MIN, 32'hFFFF_FFF0));
        send_item(mk(1'b0, 0, 0, 32'hFFFF_FFF0));
        send_item(mk(1'b0, 5, 5, 32'h7FFF_FFF0));
        send_item(mk(1'b0, POS_MIN, POS_MAX, 32'h0000_0010));
        send_item(mk(1'b0, POS_MAX, POS_MIN, 32'h0000_0011));
        send_item(mk(1'b0, 0, 0, 32'h8000_0010));
        send_item(mk(1'b0, 1, -1, 32'h8000_000F));
        send_item(mk(1'b1, 0, 0, 0));
        send_item(mk(1'b0, 0, 0, 0));
        send_item(mk(1'b0, 256, -256, 1000));
        send_item(mk(1'b0, 512, -512, 2000));

        // full gain and longest lead: drive velocity and prediction into saturation
        apply_regs(cfg_val(htp_pkg::GAIN_ONE), cfg_val(htp_pkg::LEAD_MAX), 1'b0);
        send_item(mk(1'b1, 0, 0, 0));
        send_item(mk(1'b0, POS_MIN, POS_MAX, 5));
        send_item(mk(1'b0, POS_MAX, POS_MIN, 6));
        send_item(mk(1'b0, POS_MIN, POS_MAX, 7));
        send_item(mk(1'b0, POS_MIN, POS_MAX, 7));

        apply_regs('0, '0, 1'b0);
        send_item(mk(1'b0, 1000, 2000, 100));
        send_item(mk(1'b0, -3000, 7000, 5100));
        send_item(mk(1'b0, POS_MAX, POS_MIN, 5101));

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: apply_regs(cfg_val(htp_pkg::GAIN_RESET), cfg_val(htp_pkg::LEAD_RESET), 1'b0);
                1: apply_regs(20'hFFFFF, 20'hFFFFF, 1'b0);
                2: apply_regs('0, '0, 1'b0);
                3: apply_regs(cfg_val($urandom_range(655, 65536)),
                              cfg_val($urandom_range(0, 1000000)), 1'b0);
                4: apply_regs(cfg_val($urandom_range(0, 20'hFFFFF)),
                              cfg_val($urandom_range(0, 20'hFFFFF)), 1'b1);
                5: apply_regs(cfg_val(htp_pkg::GAIN_MIN), cfg_val(htp_pkg::LEAD_MAX), 1'b0);
                6: apply_regs(cfg_val(htp_pkg::GAIN_ONE), '0, 1'b0);
                default: apply_regs(cfg_val($urandom_range(655, 65536)),
                                    cfg_val($urandom_range(0, 1000000)), 1'b1);
            endcase
            case (phase % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 60; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 60; end
                default: begin gap_pct = 6; stall_pct = 6; end
            endcase
            repeat (ITEMS_PER_PHASE) begin
                // hold off now and then until the pipeline is empty
                if ($urandom_range(99) == 0) drain_results();
                send_item(next_sample());
            end
        end

        drain_results();
        repeat (100) @(posedge aclk);

        $display("Covered %0d samples: %0d filter updates, %0d skipped steps, %0d clears",
                 sb.n_samples, sb.n_updates, sb.n_skips, sb.n_clears);
        $display("Ran %0d register settings under four pacing modes; %0d results checked",
                 NUM_PHASES + 3, sb.n_results);
        if (sb.fails == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
